@@ rtl/sfsf_pkg.sv @@
// Package with the payload types, register indexes and pipeline record of the spectrum fold.
`timescale 1ns / 1ps
package sfsf_pkg;

  localparam int MAX_SHIFT_DEF = 512;
  localparam int SEARCH_BITS   = 31;

  localparam logic [1:0] REG_SHIFT    = 2'd0;
  localparam logic [1:0] REG_ORDER    = 2'd1;
  localparam logic [1:0] REG_ERR_MODE = 2'd2;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic signed [31:0] sample_error;
    logic               end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] folded_value;
    logic signed [31:0] folded_error;
    logic               error_valid;
    logic               last_result;
  } out_item_t;

  // One record travels down the pipeline; each stage fills the fields it owns.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               self_pair;
    logic               order;
    logic               diff_mode;
    logic               zero_err;
    logic signed [31:0] v2;
    logic signed [31:0] e2;
    logic [31:0]        val;
    logic [31:0]        derr;
    logic [31:0]        m1;
    logic [31:0]        m2;
    logic [63:0]        p;
    logic [63:0]        sq1;
    logic [63:0]        sq2;
    logic [63:0]        s;
    logic [63:0]        pll;
    logic [63:0]        plh;
    logic [63:0]        phh;
    logic [127:0]       rem;
    logic [127:0]       y;
    logic [30:0]        q;
  } stage_t;

endpackage

@@ rtl/sfsf_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sfsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spectrum_frequency_switch_fold.sv @@
// Top level of the frequency-switched spectrum fold: delay line, pairing and error pipeline.
`timescale 1ns / 1ps
// Channels of a scan stream in one item per cycle, and the block keeps that rate for
// good: every stage is registered and the whole pipeline advances together, so an item
// can be taken on every clock edge at which the result register is free or being read.
// Each channel is written into a delay line held in one RAM of 2*MAX_SHIFT entries of
// 64 bits; once 2*S channels of the current scan have arrived (S being the shift
// register, limited to MAX_SHIFT) a channel is paired with the one 2*S places earlier
// and gives one result, otherwise it gives none. Once accepted, a channel passes in
// order the stage that captures it beside the RAM read of its partner, the stages for
// the magnitudes, the 32 by 32 bit products and the sum of squares, the search stages
// for the quadrature error, which is found one bit a stage by a restoring search that
// needs only shifts, adds and one compare per stage, and the result register. The delay
// line needs no clearing after reset, because an entry is only read once it was written
// in the current scan. Configuration is taken at any time (cfg_ready is always high) but
// must only be written while no item is in flight.
module spectrum_frequency_switch_fold #(
  parameter int MAX_SHIFT = sfsf_pkg::MAX_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfsf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfsf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import sfsf_pkg::*;

  localparam int DEPTH = 2 * MAX_SHIFT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int NST   = 5 + SEARCH_BITS;

  // Configuration registers.
  logic [9:0] shift_r;
  logic       order_r;
  logic       err_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      order_r    <= 1'b0;
      err_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHIFT:    shift_r    <= cfg_data;
        REG_ORDER:    order_r    <= cfg_data[0];
        REG_ERR_MODE: err_mode_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // The pipeline moves as one; it halts only while a finished result waits unread.
  logic out_valid_r;
  logic en;
  logic accept;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // Delay line pointers and the channel count of the current scan.
  logic [AW-1:0] wp_r;
  logic [CW-1:0] filled_r;
  logic [CW-1:0] sh;
  logic [CW-1:0] pair_dist;
  logic [CW-1:0] rd_wide;
  logic [AW-1:0] rd_addr;
  logic          produce;

  always_comb begin
    if (32'(shift_r) > 32'(MAX_SHIFT)) begin
      sh = CW'(MAX_SHIFT);
    end else begin
      sh = CW'(shift_r);
    end
    pair_dist = sh << 1;
    if ({1'b0, wp_r} >= pair_dist) begin
      rd_wide = {1'b0, wp_r} - pair_dist;
    end else begin
      rd_wide = {1'b0, wp_r} + CW'(DEPTH) - pair_dist;
    end
    rd_addr = rd_wide[AW-1:0];
    produce = filled_r >= pair_dist;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      filled_r <= '0;
    end else if (accept) begin
      if (32'(wp_r) + 1 >= DEPTH) begin
        wp_r <= '0;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
      if (in_data.end_of_scan) begin
        filled_r <= '0;
      end else if (filled_r < CW'(DEPTH)) begin
        filled_r <= filled_r + CW'(1);
      end
    end
  end

  logic [63:0] rd_data;

  sfsf_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_delay (
    .clk  (clk),
    .we   (accept),
    .waddr(wp_r),
    .wdata({in_data.sample_error, in_data.sample_value}),
    .re   (en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  stage_t st_r  [NST];
  stage_t st_nxt[NST];

  // Stage 0: capture the channel alongside the RAM read of its partner.
  always_comb begin
    st_nxt[0]           = st_r[0];
    st_nxt[0].valid     = accept && produce;
    st_nxt[0].last      = in_data.end_of_scan;
    st_nxt[0].self_pair = (pair_dist == '0);
    st_nxt[0].order     = order_r;
    st_nxt[0].diff_mode = err_mode_r;
    st_nxt[0].v2        = in_data.sample_value;
    st_nxt[0].e2        = in_data.sample_error;
  end

  // Stage 1: form the halved differences and the error magnitudes.
  logic signed [31:0] v1;
  logic signed [31:0] e1;
  logic signed [32:0] vd;
  logic signed [32:0] ed;

  always_comb begin
    st_nxt[1] = st_r[0];
    if (st_r[0].self_pair) begin
      v1 = st_r[0].v2;
      e1 = st_r[0].e2;
    end else begin
      v1 = rd_data[31:0];
      e1 = rd_data[63:32];
    end
    if (!st_r[0].order) begin
      vd = 33'(v1) - 33'(st_r[0].v2);
      ed = 33'(e1) - 33'(st_r[0].e2);
    end else begin
      vd = 33'(st_r[0].v2) - 33'(v1);
      ed = 33'(st_r[0].e2) - 33'(e1);
    end
    st_nxt[1].val      = 32'(vd >>> 1);
    st_nxt[1].derr     = 32'(ed >>> 1);
    st_nxt[1].m1       = e1[31] ? 32'(-33'(e1)) : 32'(e1);
    st_nxt[1].m2       = st_r[0].e2[31] ? 32'(-33'(st_r[0].e2)) : 32'(st_r[0].e2);
    st_nxt[1].zero_err = (e1 == '0) || (st_r[0].e2 == '0);
  end

  // Stage 2: the product and the two squares of the magnitudes.
  always_comb begin
    st_nxt[2]     = st_r[1];
    st_nxt[2].p   = 64'(st_r[1].m1) * 64'(st_r[1].m2);
    st_nxt[2].sq1 = 64'(st_r[1].m1) * 64'(st_r[1].m1);
    st_nxt[2].sq2 = 64'(st_r[1].m2) * 64'(st_r[1].m2);
  end

  // Stage 3: sum of squares and the partial products of the squared product.
  always_comb begin
    st_nxt[3]     = st_r[2];
    st_nxt[3].s   = st_r[2].sq1 + st_r[2].sq2;
    st_nxt[3].pll = 64'(st_r[2].p[31:0]) * 64'(st_r[2].p[31:0]);
    st_nxt[3].plh = 64'(st_r[2].p[31:0]) * 64'(st_r[2].p[63:32]);
    st_nxt[3].phh = 64'(st_r[2].p[63:32]) * 64'(st_r[2].p[63:32]);
  end

  // Stage 4: assemble the squared product as the starting remainder of the search.
  always_comb begin
    st_nxt[4]     = st_r[3];
    st_nxt[4].rem = ({64'd0, st_r[3].phh} << 64) + ({64'd0, st_r[3].plh} << 33)
                  + {64'd0, st_r[3].pll};
    st_nxt[4].y   = '0;
    st_nxt[4].q   = '0;
  end

  // Search stages: with y = s*q and rem = p*p - 4*q*q*s, setting bit b of q costs
  // (y << (b+3)) + (s << (2b+2)), which is kept when it does not exceed the remainder.
  for (genvar k = 0; k < SEARCH_BITS; k++) begin : g_search
    localparam int B = SEARCH_BITS - 1 - k;
    logic [127:0] cost;
    always_comb begin
      st_nxt[5+k] = st_r[4+k];
      cost = (st_r[4+k].y << (B + 3)) + ({64'd0, st_r[4+k].s} << (2 * B + 2));
      if (cost <= st_r[4+k].rem) begin
        st_nxt[5+k].rem  = st_r[4+k].rem - cost;
        st_nxt[5+k].y    = st_r[4+k].y + ({64'd0, st_r[4+k].s} << B);
        st_nxt[5+k].q[B] = 1'b1;
      end
    end
  end

  for (genvar j = 0; j < NST; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].valid <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  // Result register.
  out_item_t out_r;
  out_item_t out_nxt;

  always_comb begin
    out_nxt.folded_value = st_r[NST-1].val;
    out_nxt.last_result  = st_r[NST-1].last;
    if (st_r[NST-1].diff_mode) begin
      out_nxt.folded_error = st_r[NST-1].derr;
      out_nxt.error_valid  = 1'b1;
    end else if (st_r[NST-1].zero_err) begin
      out_nxt.folded_error = '0;
      out_nxt.error_valid  = 1'b0;
    end else begin
      out_nxt.folded_error = {1'b0, st_r[NST-1].q};
      out_nxt.error_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_r[NST-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/tb.sv @@
// Testbench for the frequency-switched spectrum fold: directed, stalled and random scans checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import sfsf_pkg::*;

  localparam int DEPTH    = 2 * MAX_SHIFT_DEF;
  localparam int LATENCY  = 37;
  localparam int WD_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  spectrum_frequency_switch_fold dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: its own copy of the delay line and the registers.
  logic [63:0] line_mem [DEPTH];
  int unsigned wr_pos;
  int unsigned fill_cnt;
  logic [9:0]  shift_reg;
  logic        order_reg;
  logic        diffmode_reg;

  out_item_t   pending_folds[$];
  int          fail_count;
  int          idle_cycles;
  bit          hold_long;
  int          hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact floor of |a*b| / (2*sqrt(a^2+b^2)), one bit at a time.
  function automatic logic [31:0] quad_combine(logic signed [31:0] a, logic signed [31:0] b);
    logic [63:0]  ma, mb;
    logic [127:0] pp, ss, trial;
    logic [31:0]  q, c;
    ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
    mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
    pp = (ma * mb) * (ma * mb);
    ss = ma * ma + mb * mb;
    q = 0;
    for (int i = 30; i >= 0; i--) begin
      c = q | (32'd1 << i);
      trial = 128'd4 * c * c * ss;
      if (trial <= pp) q = c;
    end
    return q;
  endfunction

  function automatic logic [31:0] half_diff(logic signed [31:0] x, logic signed [31:0] y);
    logic signed [32:0] d;
    d = {x[31], x} - {y[31], y};
    return d[32:1];
  endfunction

  // Works out the result of one accepted channel, if it forms a pair.
  task automatic predict_fold(in_item_t it);
    int unsigned sh, pair_dist, ri;
    logic signed [31:0] v1, e1;
    out_item_t r;
    sh = (shift_reg > MAX_SHIFT_DEF) ? MAX_SHIFT_DEF : shift_reg;
    pair_dist = 2 * sh;
    if (fill_cnt >= pair_dist) begin
      if (pair_dist == 0) begin
        v1 = it.sample_value;
        e1 = it.sample_error;
      end else begin
        ri = (wr_pos >= pair_dist) ? wr_pos - pair_dist : wr_pos + DEPTH - pair_dist;
        v1 = line_mem[ri][31:0];
        e1 = line_mem[ri][63:32];
      end
      r.folded_value = order_reg ? half_diff(it.sample_value, v1)
                                 : half_diff(v1, it.sample_value);
      r.error_valid = 1'b1;
      if (diffmode_reg) begin
        r.folded_error = order_reg ? half_diff(it.sample_error, e1)
                                   : half_diff(e1, it.sample_error);
      end else if (e1 != 0 && it.sample_error != 0) begin
        r.folded_error = quad_combine(e1, it.sample_error);
      end else begin
        r.folded_error = 0;
        r.error_valid = 1'b0;
      end
      r.last_result = it.end_of_scan;
      pending_folds.push_back(r);
    end
    line_mem[wr_pos] = {it.sample_error, it.sample_value};
    wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
    if (fill_cnt < DEPTH) fill_cnt++;
    if (it.end_of_scan) fill_cnt = 0;
  endtask

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one item and waits until it is taken. Valid stays high afterwards, so
  // the caller drops it once no item follows.
  task automatic send_channel(logic signed [31:0] v, logic signed [31:0] e, logic eos,
                              bit gaps = 1);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_value: v, sample_error: e, end_of_scan: eos};
    do @(posedge clk); while (in_stall);
    predict_fold('{sample_value: v, sample_error: e, end_of_scan: eos});
  endtask

  // Waits until every result has arrived, then for the pipeline to drain.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHIFT:    shift_reg = val;
      REG_ORDER:    order_reg = val[0];
      REG_ERR_MODE: diffmode_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic [9:0] sh, logic ord, logic dm);
    drain_pipeline();
    write_reg(REG_SHIFT, sh);
    write_reg(REG_ORDER, {9'd0, ord});
    write_reg(REG_ERR_MODE, {9'd0, dm});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(3) - 1;
      4: return $urandom_range(255) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Extremes of the fields, zero shift, short scans and zero errors.
  task automatic test_directed();
    set_mode(10'd0, 1'b0, 1'b0);
    send_channel(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_channel(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_channel(32'd5, 32'd0, 1'b1);
    set_mode(10'd1, 1'b0, 1'b0);
    send_channel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_channel(32'h0001_0000, 32'h8000_0000, 1'b0);
    send_channel(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_channel(-32'sd3, 32'd0, 1'b0);
    send_channel(32'd7, 32'h0002_0000, 1'b1);
    // Scan shorter than the pairing distance gives nothing.
    send_channel(32'd1, 32'd1, 1'b1);
    set_mode(10'd1, 1'b1, 1'b1);
    send_channel(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_channel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_channel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_channel(-32'sd1, -32'sd1, 1'b1);
    // Shift above the maximum is clamped.
    set_mode(10'h3FF, 1'b0, 1'b1);
    for (int i = 0; i < 3; i++) send_channel($urandom, $urandom, 1'b0, 0);
    send_channel(32'd9, 32'd9, 1'b1);
  endtask

  // Random scans under several settings, the extremes included.
  task automatic test_random_scans();
    int total, len;
    logic [9:0] sh;
    total = 0;
    while (total < 1500) begin
      case ($urandom_range(5))
        0: sh = '0;
        // A long shift only early on, so the item count stays near its target.
        1: sh = (total < 400) ? 10'(512 + $urandom_range(511)) : 10'($urandom_range(40, 1));
        2: sh = 10'($urandom_range(40, 1));
        default: sh = 10'($urandom_range(4, 1));
      endcase
      set_mode(sh, 1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int s = 0; s < 4; s++) begin
        if (sh > 60) len = 2 * MAX_SHIFT_DEF + $urandom_range(30);
        else len = $urandom_range(8) == 0 ? $urandom_range(2 * sh) : 2 * sh + $urandom_range(40);
        for (int k = 0; k < len; k++)
          send_channel(rand_word(), rand_word(), k == len - 1);
        total += len;
        if (sh > 60) break;
      end
    end
  endtask

  // The receiver holds off for a long stretch while channels keep coming.
  task automatic test_backpressure();
    set_mode(10'd2, 1'b1, 1'b0);
    hold_len = 300;
    hold_long = 1'b1;
    for (int k = 0; k < 120; k++) send_channel($urandom, $urandom, k == 119, 0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (hold_long) @(posedge clk);
    drain_pipeline();
  endtask

  // Receiver side: random stalls, plus the long hold when asked.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_long = 1'b0;
      end else if ($urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_folds.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_folds.pop_front();
        if (want !== out_data) begin
          $display("%0t expected %p actual %p", $time, want, out_data);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("spectrum_frequency_switch_fold: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    hold_long = 1'b0;
    hold_len = 0;
    wr_pos = 0;
    fill_cnt = 0;
    shift_reg = 0;
    order_reg = 0;
    diffmode_reg = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_scans();
    drain_pipeline();
    if (fail_count == 0 && pending_folds.size() == 0)
      $display("spectrum_frequency_switch_fold: match");
    else
      $display("spectrum_frequency_switch_fold: mismatch");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/sfsf_pkg.sv
rtl/sfsf_ram.sv
rtl/spectrum_frequency_switch_fold.sv
tb/tb.sv
